### rtl/core/cuem_pkg.sv
// Shared types and constants of the CPU utilization EWMA meter.
// Sample, queue and result words, status and command codes, datapath widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cuem_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int STAMP_BITS = 48;

    localparam int BUSY_W    = 63;
    localparam int STAMP_W   = 48;
    localparam int MC_W      = 32;
    localparam int CORE_W    = MC_W - 1;
    localparam int US_W      = 10;
    localparam int M_W       = CORE_W + US_W;
    localparam int DEN_W     = STAMP_BITS + M_W;
    localparam int QUOT_W    = 32;
    localparam int NUM_W     = BUSY_W + FRAC_BITS;
    localparam int DVS_W     = DEN_W + QUOT_W;
    localparam int CNT_W     = $clog2(QUOT_W);
    localparam int ALPHA_W   = 16;
    localparam int P_W       = ALPHA_W + 1 + QUOT_W;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [US_W-1:0]    US_PER_MS   = 10'd1000;
    localparam logic [ALPHA_W:0]   ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_HALF  = 16'd32768;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;

    typedef enum logic
    {
        CMD_PRIME  = 1'b0,
        CMD_UPDATE = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_BAD_ALLOC  = 3'd2,
        ST_NO_WORK    = 3'd3,
        ST_NO_ELAPSED = 3'd4
    } status_t;

    typedef struct packed
    {
        cmd_t                     cmd;
        logic                     stats_valid;
        logic [BUSY_W-1:0]        busy_time_ns;
        logic [STAMP_W-1:0]       stamp_ms;
        logic signed [MC_W-1:0]   allocated_millicores;
    } in_word_t;

    typedef struct packed
    {
        status_t                  status;
        logic [QUOT_W-1:0]        utilization_q16;
    } out_word_t;

    typedef struct packed
    {
        cmd_t                     cmd;
        status_t                  status;
        logic [BUSY_W-1:0]        busy_delta;
        logic [STAMP_BITS-1:0]    elapsed;
        logic [CORE_W-1:0]        cores;
    } q_word_t;

endpackage

`default_nettype wire

### rtl/core/cuem_front.sv
// Front end: accepts sample words, checks them against the baseline, forms deltas.
// Owns the baseline busy time and timestamp. Depends on cuem_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cuem_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cuem_pkg::in_word_t sample,
    input  logic               q_full,
    output logic               q_push,
    output cuem_pkg::q_word_t  q_word
);
    import cuem_pkg::*;

    logic [BUSY_W-1:0]     base_busy_reg, base_busy_next;
    logic [STAMP_BITS-1:0] base_stamp_reg, base_stamp_next;
    logic [BUSY_W:0]       busy_diff;
    logic [STAMP_BITS:0]   stamp_diff;
    logic [STAMP_BITS-1:0] stamp;
    logic                  work_ok;
    logic                  elapsed_ok;
    logic                  alloc_ok;
    logic                  accept;
    status_t               status;

    assign stamp      = sample.stamp_ms[STAMP_BITS-1:0];
    assign busy_diff  = {1'b0, sample.busy_time_ns} - {1'b0, base_busy_reg};
    assign stamp_diff = {1'b0, stamp} - {1'b0, base_stamp_reg};
    assign work_ok    = !busy_diff[BUSY_W] && (busy_diff[BUSY_W-1:0] != '0);
    assign elapsed_ok = !stamp_diff[STAMP_BITS] && (stamp_diff[STAMP_BITS-1:0] != '0);
    assign alloc_ok   = !sample.allocated_millicores[MC_W-1]
                        && (sample.allocated_millicores != '0);
    assign accept     = push && !q_full;

    always_comb
    begin
        if (!sample.stats_valid)
        begin
            status = ST_INVALID;
        end
        else if (!alloc_ok)
        begin
            status = ST_BAD_ALLOC;
        end
        else if (!work_ok)
        begin
            status = ST_NO_WORK;
        end
        else if (!elapsed_ok)
        begin
            status = ST_NO_ELAPSED;
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign q_push            = accept;
    assign q_word.cmd        = sample.cmd;
    assign q_word.status     = status;
    assign q_word.busy_delta = busy_diff[BUSY_W-1:0];
    assign q_word.elapsed    = stamp_diff[STAMP_BITS-1:0];
    assign q_word.cores      = sample.allocated_millicores[CORE_W-1:0];

    always_comb
    begin
        base_busy_next  = base_busy_reg;
        base_stamp_next = base_stamp_reg;
        if (accept && ((sample.cmd == CMD_PRIME) || (status == ST_OK)))
        begin
            base_busy_next  = sample.busy_time_ns;
            base_stamp_next = stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_busy_reg  <= '0;
            base_stamp_reg <= '0;
        end
        else
        begin
            base_busy_reg  <= base_busy_next;
            base_stamp_reg <= base_stamp_next;
        end
    end

    a_fail_keeps_base: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (sample.cmd == CMD_UPDATE) && (status != ST_OK))
        |=> ($stable(base_busy_reg) && $stable(base_stamp_reg)))
        else $error("baseline moved on a failed update");

    a_prime_loads_base: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (sample.cmd == CMD_PRIME))
        |=> (base_busy_reg == $past(sample.busy_time_ns)))
        else $error("prime did not load baseline");

endmodule

`default_nettype wire

### rtl/core/cuem_queue.sv
// Short queue of classified words between front end and back end.
// Register array with read and write pointers. Depends on cuem_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cuem_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cuem_pkg::q_word_t wr_word,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output cuem_pkg::q_word_t rd_word
);
    import cuem_pkg::*;

    q_word_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

### rtl/core/cuem_back.sv
// Back end: shift-add denominator, restoring divider, EWMA fold, result register.
// Owns the smoothed utilization. Depends on cuem_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cuem_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [cuem_pkg::ALPHA_W-1:0]   alpha,
    input  logic                           q_empty,
    output logic                           q_pop,
    input  cuem_pkg::q_word_t              q_word,
    output logic                           empty,
    input  logic                           pop,
    output cuem_pkg::out_word_t            result
);
    import cuem_pkg::*;

    typedef enum logic [7:0]
    {
        S_IDLE  = 8'b0000_0001,
        S_SCALE = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_SAT   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_EW1   = 8'b0010_0000,
        S_EW2   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [CORE_W-1:0]  cores_reg, cores_next;
    logic [M_W-1:0]     mult_reg, mult_next;
    logic [DEN_W-1:0]   mcand_reg, mcand_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [P_W-1:0]     p1_reg, p1_next;
    logic [P_W-1:0]     p2_reg, p2_next;
    logic [QUOT_W-1:0]  smooth_reg, smooth_next;
    out_word_t          res_reg, res_next;
    out_word_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic [DVS_W-1:0]   rem_ext;
    logic [P_W-1:0]     ew_sum;
    logic               out_free;

    assign rem_ext  = {{(DVS_W - NUM_W){1'b0}}, rem_reg};
    assign ew_sum   = p1_reg + p2_reg + P_W'(ALPHA_HALF);
    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        cores_next  = cores_reg;
        mult_next   = mult_reg;
        mcand_next  = mcand_reg;
        den_next    = den_reg;
        dvs_next    = dvs_reg;
        quot_next   = quot_reg;
        cnt_next    = cnt_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        smooth_next = smooth_reg;
        res_next    = res_reg;
        q_pop       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    rem_next   = {q_word.busy_delta, {FRAC_BITS{1'b0}}};
                    mcand_next = {{M_W{1'b0}}, q_word.elapsed};
                    den_next   = '0;
                    cores_next = q_word.cores;
                    if (q_word.cmd == CMD_PRIME)
                    begin
                        res_next.status          = ST_OK;
                        res_next.utilization_q16 = smooth_reg;
                        state_next               = S_DONE;
                    end
                    else if (q_word.status != ST_OK)
                    begin
                        res_next.status          = q_word.status;
                        res_next.utilization_q16 = '0;
                        state_next               = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCALE;
                    end
                end
            end
            S_SCALE:
            begin
                mult_next  = {{US_W{1'b0}}, cores_reg} * {{CORE_W{1'b0}}, US_PER_MS};
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mult_reg == '0)
                begin
                    dvs_next   = {den_reg, {QUOT_W{1'b0}}};
                    state_next = S_SAT;
                end
                else
                begin
                    if (mult_reg[0])
                    begin
                        den_next = den_reg + mcand_reg;
                    end
                    mcand_next = mcand_reg << 1;
                    mult_next  = mult_reg >> 1;
                end
            end
            S_SAT:
            begin
                if (rem_ext >= dvs_reg)
                begin
                    quot_next  = '1;
                    state_next = S_EW1;
                end
                else
                begin
                    quot_next  = '0;
                    dvs_next   = dvs_reg >> 1;
                    cnt_next   = CNT_W'(QUOT_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_ext >= dvs_reg)
                begin
                    rem_next  = rem_reg - dvs_reg[NUM_W-1:0];
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
                end
                dvs_next = dvs_reg >> 1;
                if (cnt_reg == '0)
                begin
                    state_next = S_EW1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_EW1:
            begin
                p1_next    = P_W'(alpha) * P_W'(quot_reg);
                p2_next    = P_W'(ALPHA_ONE - {1'b0, alpha}) * P_W'(smooth_reg);
                state_next = S_EW2;
            end
            S_EW2:
            begin
                smooth_next              = ew_sum[ALPHA_W+QUOT_W-1:ALPHA_W];
                res_next.status          = ST_OK;
                res_next.utilization_q16 = ew_sum[ALPHA_W+QUOT_W-1:ALPHA_W];
                state_next               = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if ((state_reg == S_DONE) && out_free)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            smooth_reg    <= smooth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        cores_reg <= cores_next;
        mult_reg  <= mult_next;
        mcand_reg <= mcand_next;
        den_reg   <= den_next;
        dvs_reg   <= dvs_next;
        quot_reg  <= quot_next;
        cnt_reg   <= cnt_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ({1'b0, rem_ext} < {dvs_reg, 1'b0}))
        else $error("divider remainder out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != ST_OK)) |-> (out_reg.utilization_q16 == '0))
        else $error("failed word carries nonzero utilization");

    a_smooth_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EW2) |=> $stable(smooth_reg))
        else $error("smoothed value changed outside the fold step");

endmodule

`default_nettype wire

### rtl/core/cpu_utilization_ewma_meter.sv
// CPU utilization meter with exponentially weighted smoothing.
// Sample queue in (push/full), result queue out (empty/pop), one config register.
// Each accepted sample word gives exactly one result word, in order.
// Prime words (cmd 0) store the baseline; update words (cmd 1) check the
// sample, divide busy delta by elapsed*1000*millicores into Q16.16 and fold
// it into the running average with weight alpha_q16.
// Order of work: a prime word or a failed update goes from the queue straight
// to the result register. A passing update runs the shift-add multiplier (one
// bit of millicores*1000 a cycle) and then the restoring divider (one quotient
// bit a cycle) in the back end; a saturating quotient skips the divider. The
// back end takes its next word in the cycle after a result leaves it, so it
// does not start a new word before the last one has left.
// The front end checks and queues words while the back end works, so it
// takes up to two further words; the back end handles one word at a time.
// A result word holds on the result port until popped; while it waits the
// back end stalls once it holds the next result, the queue fills, then full rises.
// Reset clears baseline, average and queues; alpha_q16 returns to 3277.
// Write alpha_q16 through cfg_wen/cfg_wdata only while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module cpu_utilization_ewma_meter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  cuem_pkg::in_word_t            sample,
    output logic                          empty,
    input  logic                          pop,
    output cuem_pkg::out_word_t           result,
    input  logic                          cfg_wen,
    input  logic [cuem_pkg::ALPHA_W-1:0]  cfg_wdata
);
    import cuem_pkg::*;

    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic               fq_push;
    logic               fq_full;
    logic               fq_pop;
    logic               fq_empty;
    q_word_t            fq_wr_word;
    q_word_t            fq_rd_word;

    assign full = fq_full;

    always_comb
    begin
        alpha_next = alpha_reg;
        if (cfg_wen)
        begin
            alpha_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
        end
        else
        begin
            alpha_reg <= alpha_next;
        end
    end

    cuem_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .sample (sample),
        .q_full (fq_full),
        .q_push (fq_push),
        .q_word (fq_wr_word)
    );

    cuem_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .wr_word (fq_wr_word),
        .full    (fq_full),
        .pop     (fq_pop),
        .empty   (fq_empty),
        .rd_word (fq_rd_word)
    );

    cuem_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .alpha   (alpha_reg),
        .q_empty (fq_empty),
        .q_pop   (fq_pop),
        .q_word  (fq_rd_word),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire
